// ===== rtl/cbi_pkg.sv =====
// ---------------------------------------------------------------------------
// cbi_pkg: shared constants for the convolutional byte interleaver
// Branch count, unit delay depth and derived sizes of the cell chain.
// ---------------------------------------------------------------------------
package cbi_pkg;

  localparam int BRANCHES   = 12;
  localparam int UNIT_DEPTH = 17;
  localparam int BYTE_W     = 8;

  // branch b holds b cells, so the chain has 0+1+...+(BRANCHES-1) cells
  localparam int NUM_CELLS  = BRANCHES * (BRANCHES - 1) / 2;
  localparam int BRANCH_W   = (BRANCHES > 1) ? $clog2(BRANCHES) : 1;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [BRANCH_W-1:0] branch_t;

endpackage

// ===== rtl/convolutional_byte_interleaver.sv =====
// ---------------------------------------------------------------------------
// convolutional_byte_interleaver: Forney byte interleaver, I=12, M=17
// Branch b delays its bytes by b*17 visits through a chain of b cells.
// ---------------------------------------------------------------------------
// Usage:
//   s_* : input stream, one byte per word (s_tdata[7:0] = data_in).
//   m_* : output stream, one byte per word (m_tdata[7:0] = out_byte).
//   Every accepted input word produces exactly one output word.
//   A branch counter steps through the 12 branches, one per word. Branch 0
//   passes the byte through; branch b feeds b cells of 17 bytes in series,
//   which shift only when their branch is selected.
//   The result word is registered and is valid in the cycle after the input is taken.
//   Throughput: one word per clock; the output register is refilled in the
//   same cycle it is drained, so s_tready stays high while m_tready is high.
//   Stall: when m_tready is low with a word held, s_tready drops and the
//   cells and counter hold still.
//   Reset (rst, synchronous): all cells are cleared to zero and the counter
//   returns to branch 0, so each branch first outputs b*17 zero bytes.
//   No clearing pass is needed; the block takes words right after reset.
// ---------------------------------------------------------------------------
module convolutional_byte_interleaver (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_in
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [7:0] out_byte
);

  localparam int NB = cbi_pkg::BRANCHES;

  cbi_pkg::branch_t branch;
  cbi_pkg::branch_t branch_next;
  cbi_pkg::byte_t   cell_out [cbi_pkg::NUM_CELLS];
  cbi_pkg::byte_t   tail     [NB];
  cbi_pkg::byte_t   data_sel;
  logic             accept;

  // output register is free when empty or being drained this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // branch 0: straight through
  assign tail[0] = s_tdata;

  genvar b, c;
  generate
    for (b = 1; b < NB; b++) begin : g_branch
      localparam int Base = b * (b - 1) / 2;
      logic en;
      assign en = accept && (branch == cbi_pkg::BRANCH_W'(b));

      for (c = 0; c < b; c++) begin : g_cell
        cbi_pkg::byte_t din;
        if (c == 0) begin : g_head
          assign din = s_tdata;
        end else begin : g_link
          assign din = cell_out[Base + c - 1];
        end

        cbi_cell u_cell (
          .clk  (clk),
          .rst  (rst),
          .en   (en),
          .din  (din),
          .dout (cell_out[Base + c])
        );
      end

      // last cell of the branch gives the byte that entered b*M visits ago
      assign tail[b] = cell_out[Base + b - 1];
    end
  endgenerate

  always_comb begin
    data_sel = tail[branch];
    if (branch == cbi_pkg::BRANCH_W'(NB - 1)) begin
      branch_next = '0;
    end else begin
      branch_next = branch + cbi_pkg::BRANCH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      branch   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        branch   <= branch_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= data_sel;
    end
  end

endmodule

// ===== rtl/cbi_cell.sv =====
// ---------------------------------------------------------------------------
// cbi_cell: one unit delay of the interleaver
// Shift line of UNIT_DEPTH bytes that advances only when its branch is hit.
// ---------------------------------------------------------------------------
module cbi_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  cbi_pkg::byte_t din,
  output cbi_pkg::byte_t dout
);

  cbi_pkg::byte_t taps [cbi_pkg::UNIT_DEPTH];

  // oldest byte leaves before the shift
  assign dout = taps[cbi_pkg::UNIT_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbi_pkg::UNIT_DEPTH; i++) begin
        taps[i] <= '0;
      end
    end else if (en) begin
      taps[0] <= din;
      for (int i = 1; i < cbi_pkg::UNIT_DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

endmodule
